@@ rtl/core/lorenz_rk4_tangent_step_core_assert.svh @@
// Assertion macros for the Lorenz RK4 core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LORENZ_RK4_TANGENT_STEP_CORE_ASSERT_SVH
`define LORENZ_RK4_TANGENT_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define LRK_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lorenz core check failed");

// next-cycle implication
`define LRK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lorenz core check failed");

`endif

@@ rtl/core/lrk_pkg.sv @@
// Types, codes and microprogram for the Lorenz RK4 tangent step core.
// No dependencies; used by every module of the core.
package lrk_pkg;

	localparam int VAL_W = 64;
	localparam int ROM_LEN = 256;
	localparam int UPC_W = 8;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_WSAT, OP_DIV6, OP_JLD, OP_END
	} op_t;

	typedef enum logic [1:0] {SH_FRAC, SH_32, SH_33} sh_t;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_FETCH, SQ_READ, SQ_START, SQ_WAIT, SQ_WB, SQ_DONE
	} sq_state_t;

	localparam logic [1:0] CFG_SIGMA = 2'd0;
	localparam logic [1:0] CFG_RHO = 2'd1;
	localparam logic [1:0] CFG_BETA = 2'd2;
	localparam logic [1:0] CFG_DT = 2'd3;

	// operand codes: bit 5 clear is scratch memory, set is a fixed source
	localparam logic [5:0] R_K0 = 6'd0;
	localparam logic [5:0] R_ST0 = 6'd12;
	localparam logic [5:0] R_T1 = 6'd15;
	localparam logic [5:0] R_T2 = 6'd16;
	localparam logic [5:0] R_SIG = 6'd32;
	localparam logic [5:0] R_RHO = 6'd33;
	localparam logic [5:0] R_BETA = 6'd34;
	localparam logic [5:0] R_DT = 6'd35;
	localparam logic [5:0] R_PX = 6'd36;
	localparam logic [5:0] R_PY = 6'd37;
	localparam logic [5:0] R_PZ = 6'd38;
	localparam logic [5:0] R_TX = 6'd39;
	localparam logic [5:0] R_TY = 6'd40;
	localparam logic [5:0] R_TZ = 6'd41;
	localparam logic [5:0] R_LX = 6'd42;
	localparam logic [5:0] R_LY = 6'd43;
	localparam logic [5:0] R_LZ = 6'd44;
	localparam logic [5:0] R_LTX = 6'd45;
	localparam logic [5:0] R_LTY = 6'd46;
	localparam logic [5:0] R_LTZ = 6'd47;

	typedef struct packed {
		logic               action;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic signed [31:0] load_z;
		logic signed [31:0] load_tx;
		logic signed [31:0] load_ty;
		logic signed [31:0] load_tz;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_tx;
		logic signed [31:0] out_ty;
		logic signed [31:0] out_tz;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		op_t              op;
		sh_t              sh;
		logic [5:0]       dst;
		logic [5:0]       sa;
		logic [5:0]       sb;
		logic [UPC_W-1:0] tgt;
	} uword_t;

	typedef uword_t [ROM_LEN-1:0] urom_t;

	typedef struct packed {
		logic       rd;
		logic       start;
		logic       wb;
		logic       fin;
		op_t        op;
		sh_t        sh;
		logic [5:0] dst;
		logic [5:0] sa;
		logic [5:0] sb;
	} seq_ctrl_t;

	function automatic uword_t uw(op_t op, logic [5:0] d, logic [5:0] a, logic [5:0] b,
		sh_t sh);
		uword_t w;
		w.op = op;
		w.sh = sh;
		w.dst = d;
		w.sa = a;
		w.sb = b;
		w.tgt = '0;
		return w;
	endfunction

	function automatic logic [5:0] kreg(int i, int j);
		return R_K0 + 6'(i * 3 + j);
	endfunction

	function automatic urom_t build_rom();
		urom_t r;
		int pc;
		int i;
		int j;
		int pass;
		logic [5:0] bs [3];
		logic [5:0] s [3];
		for (i = 0; i < ROM_LEN; i++) r[i] = uw(OP_END, '0, '0, '0, SH_FRAC);
		r[0] = uw(OP_JLD, '0, '0, '0, SH_FRAC);
		pc = 1;
		for (pass = 0; pass < 2; pass++) begin
			for (j = 0; j < 3; j++)
				bs[j] = (pass == 0) ? (R_TX + 6'(j)) : (R_PX + 6'(j));
			for (i = 0; i < 4; i++) begin
				for (j = 0; j < 3; j++)
					s[j] = (i == 0) ? bs[j] : (R_ST0 + 6'(j));
				r[pc] = uw(OP_SUB, R_T1, s[1], s[0], SH_FRAC); pc++;
				r[pc] = uw(OP_MUL, kreg(i, 0), R_SIG, R_T1, SH_FRAC); pc++;
				if (pass == 0) begin
					r[pc] = uw(OP_SUB, R_T1, R_RHO, R_PZ, SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T1, R_T1, s[0], SH_FRAC); pc++;
					r[pc] = uw(OP_SUB, R_T1, R_T1, s[1], SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T2, R_PX, s[2], SH_FRAC); pc++;
					r[pc] = uw(OP_SUB, kreg(i, 1), R_T1, R_T2, SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T1, R_PX, s[1], SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T2, s[0], R_PY, SH_FRAC); pc++;
					r[pc] = uw(OP_ADD, R_T1, R_T1, R_T2, SH_FRAC); pc++;
				end else begin
					r[pc] = uw(OP_MUL, R_T1, R_RHO, s[0], SH_FRAC); pc++;
					r[pc] = uw(OP_SUB, R_T1, R_T1, s[1], SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T2, s[0], s[2], SH_FRAC); pc++;
					r[pc] = uw(OP_SUB, kreg(i, 1), R_T1, R_T2, SH_FRAC); pc++;
					r[pc] = uw(OP_MUL, R_T1, s[0], s[1], SH_FRAC); pc++;
				end
				r[pc] = uw(OP_MUL, R_T2, R_BETA, s[2], SH_FRAC); pc++;
				r[pc] = uw(OP_SUB, kreg(i, 2), R_T1, R_T2, SH_FRAC); pc++;
				if (i < 3) begin
					for (j = 0; j < 3; j++) begin
						r[pc] = uw(OP_MUL, R_T1, kreg(i, j), R_DT, (i < 2) ? SH_33 : SH_32);
						pc++;
						r[pc] = uw(OP_ADD, R_T1, bs[j], R_T1, SH_FRAC); pc++;
						r[pc] = uw(OP_WSAT, R_ST0 + 6'(j), R_T1, R_T1, SH_FRAC); pc++;
					end
				end
			end
			for (j = 0; j < 3; j++) begin
				r[pc] = uw(OP_ADD, R_T1, kreg(1, j), kreg(1, j), SH_FRAC); pc++;
				r[pc] = uw(OP_ADD, R_T1, kreg(0, j), R_T1, SH_FRAC); pc++;
				r[pc] = uw(OP_ADD, R_T2, kreg(2, j), kreg(2, j), SH_FRAC); pc++;
				r[pc] = uw(OP_ADD, R_T2, R_T2, kreg(3, j), SH_FRAC); pc++;
				r[pc] = uw(OP_ADD, R_T1, R_T1, R_T2, SH_FRAC); pc++;
				r[pc] = uw(OP_MUL, R_T1, R_T1, R_DT, SH_32); pc++;
				r[pc] = uw(OP_DIV6, R_T1, R_T1, R_T1, SH_FRAC); pc++;
				r[pc] = uw(OP_ADD, R_T1, bs[j], R_T1, SH_FRAC); pc++;
				r[pc] = uw(OP_WSAT, bs[j], R_T1, R_T1, SH_FRAC); pc++;
			end
		end
		r[pc] = uw(OP_END, '0, '0, '0, SH_FRAC);
		pc++;
		r[0].tgt = UPC_W'(pc);
		for (j = 0; j < 6; j++) begin
			r[pc] = uw(OP_WSAT, R_PX + 6'(j), R_LX + 6'(j), R_LX + 6'(j), SH_FRAC);
			pc++;
		end
		r[pc] = uw(OP_END, '0, '0, '0, SH_FRAC);
		return r;
	endfunction

endpackage

@@ rtl/core/lrk_mul.sv @@
// Shared multiplier: 64x64 sign-magnitude product from four 32x32 partial
// products, then shift with floor rounding and 64-bit clip. Uses lrk_pkg.
module lrk_mul import lrk_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	input  sh_t              sh,
	output logic             done,
	output logic [VAL_W-1:0] res,
	output logic             clip
);

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	sh_t          sh_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  res_q;
	logic         clip_q;

	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [1:0]   pos;
	logic [6:0]   shn;
	logic [127:0] q, qr;
	logic         rem;
	logic [63:0]  fin_res;
	logic         fin_clip;

	always_comb begin
		pp = ma_q[{cnt_q[0], 5'd0} +: 32] * mb_q[{cnt_q[1], 5'd0} +: 32];
		pos = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		case (pos)
			2'd0: pp_sh = 128'(pp);
			2'd1: pp_sh = 128'(pp) << 32;
			default: pp_sh = 128'(pp) << 64;
		endcase
	end

	always_comb begin
		case (sh_q)
			SH_32: shn = 7'd32;
			SH_33: shn = 7'd33;
			default: shn = 7'(FRAC_BITS);
		endcase
		q = acc_q >> shn;
		rem = |(acc_q & ~(~128'd0 << shn));
		qr = q + 128'(neg_q & rem);
		if (!neg_q) begin
			fin_clip = |qr[127:63];
			fin_res = fin_clip ? 64'h7fff_ffff_ffff_ffff : qr[63:0];
		end else begin
			fin_clip = (|qr[127:64]) | (qr[63] & (|qr[62:0]));
			fin_res = fin_clip ? 64'h8000_0000_0000_0000 : (64'd0 - qr[63:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= a[63] ? (64'd0 - a) : a;
			mb_q <= b[63] ? (64'd0 - b) : b;
			neg_q <= a[63] ^ b[63];
			sh_q <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				res_q <= fin_res;
				clip_q <= fin_clip;
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign res = res_q;
	assign clip = clip_q;

endmodule

@@ rtl/core/lrk_div6.sv @@
// Divide-by-six unit: magnitude times the reciprocal of six from four 32x32
// partial products, quotient truncated toward zero. Uses lrk_pkg.
module lrk_div6 import lrk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] a,
	output logic             done,
	output logic [VAL_W-1:0] res
);

	// ceil(2^66 / 6); the quotient is the product shifted right by 66
	localparam logic [63:0] RECIP6 = 64'haaaa_aaaa_aaaa_aaab;

	logic [63:0]  mag_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;

	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [1:0]   pos;
	logic [63:0]  quo;

	always_comb begin
		pp = mag_q[{cnt_q[0], 5'd0} +: 32] * RECIP6[{cnt_q[1], 5'd0} +: 32];
		pos = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		case (pos)
			2'd0: pp_sh = 128'(pp);
			2'd1: pp_sh = 128'(pp) << 32;
			default: pp_sh = 128'(pp) << 64;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= a[63] ? (64'd0 - a) : a;
			neg_q <= a[63];
			acc_q <= '0;
		end else if (busy_q && cnt_q != 3'd4) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign quo = {2'b00, acc_q[127:66]};
	assign done = done_q;
	assign res = neg_q ? (64'd0 - quo) : quo;

endmodule

@@ rtl/core/lrk_dpath.sv @@
// Datapath: configuration and state registers, scratch memory, saturating
// ALU, shared multiplier and divider. Uses lrk_pkg, lrk_mul, lrk_div6.
module lrk_dpath import lrk_pkg::*; #(
	parameter int FRAC_BITS = 24,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        take,
	input  cmd_t        cmd,
	input  seq_ctrl_t   ctrl,
	output logic        done,
	output rsp_t        rsp
);

	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic [30:0] SIG_RST = 31'(ONE * 64'd10);
	localparam logic [30:0] RHO_RST = 31'(ONE * 64'd28);
	localparam logic [30:0] BETA_RST = 31'((ONE * 64'd8 + 64'd1) / 64'd3);
	localparam logic [31:0] DT_RST = 32'd4294967;
	localparam logic [WORD_BITS-1:0] POS_RST = WORD_BITS'((ONE + 64'd5) / 64'd10);
	localparam logic [WORD_BITS-1:0] TAN_RST = WORD_BITS'(ONE);
	localparam logic [63:0] WMAX = (64'd1 << (WORD_BITS - 1)) - 64'd1;
	localparam logic [63:0] WMIN = ~WMAX;

	logic [30:0] sig_q, rho_q, beta_q;
	logic [31:0] dt_q;
	logic signed [WORD_BITS-1:0] px_q, py_q, pz_q, tx_q, ty_q, tz_q;
	cmd_t        cmd_q;
	logic [63:0] mem [32];
	logic [63:0] a_q, b_q;
	logic [63:0] alu_res_q;
	logic        alu_clip_q;
	logic        clip_q;

	logic [63:0] spec_a, spec_b;
	logic [63:0] alu_res, sum, dif;
	logic        alu_clip;
	logic        mul_done, div_done, mul_clip;
	logic [63:0] mul_res, div_res;
	logic [63:0] wb_val;
	logic        wb_clip;
	logic [32:0] o_x, o_y, o_z, o_tx, o_ty, o_tz;

	function automatic logic [63:0] spec_val(input logic [5:0] s);
		logic [63:0] v;
		case (s)
			R_SIG: v = {33'd0, sig_q};
			R_RHO: v = {33'd0, rho_q};
			R_BETA: v = {33'd0, beta_q};
			R_DT: v = {32'd0, dt_q};
			R_PX: v = 64'(px_q);
			R_PY: v = 64'(py_q);
			R_PZ: v = 64'(pz_q);
			R_TX: v = 64'(tx_q);
			R_TY: v = 64'(ty_q);
			R_TZ: v = 64'(tz_q);
			R_LX: v = 64'(cmd_q.load_x);
			R_LY: v = 64'(cmd_q.load_y);
			R_LZ: v = 64'(cmd_q.load_z);
			R_LTX: v = 64'(cmd_q.load_tx);
			R_LTY: v = 64'(cmd_q.load_ty);
			R_LTZ: v = 64'(cmd_q.load_tz);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [32:0] out32(input logic signed [WORD_BITS-1:0] v);
		logic [63:0] e;
		logic        c;
		e = 64'(v);
		c = !((&e[63:31]) | ~(|e[63:31]));
		return {c, c ? (e[63] ? 32'h8000_0000 : 32'h7fff_ffff) : e[31:0]};
	endfunction

	assign spec_a = spec_val(ctrl.sa);
	assign spec_b = spec_val(ctrl.sb);

	always_comb begin
		sum = a_q + b_q;
		dif = a_q - b_q;
		case (ctrl.op)
			OP_ADD: begin
				alu_clip = (a_q[63] == b_q[63]) && (sum[63] != a_q[63]);
				alu_res = alu_clip ? (a_q[63] ? 64'h8000_0000_0000_0000
					: 64'h7fff_ffff_ffff_ffff) : sum;
			end
			OP_SUB: begin
				alu_clip = (a_q[63] != b_q[63]) && (dif[63] != a_q[63]);
				alu_res = alu_clip ? (a_q[63] ? 64'h8000_0000_0000_0000
					: 64'h7fff_ffff_ffff_ffff) : dif;
			end
			OP_WSAT: begin
				alu_clip = !((&a_q[63:WORD_BITS-1]) | ~(|a_q[63:WORD_BITS-1]));
				alu_res = alu_clip ? (a_q[63] ? WMIN : WMAX) : a_q;
			end
			default: begin
				alu_clip = 1'b0;
				alu_res = a_q;
			end
		endcase
	end

	lrk_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.start && ctrl.op == OP_MUL),
		.a     (a_q),
		.b     (b_q),
		.sh    (ctrl.sh),
		.done  (mul_done),
		.res   (mul_res),
		.clip  (mul_clip)
	);

	lrk_div6 u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctrl.start && ctrl.op == OP_DIV6),
		.a     (a_q),
		.done  (div_done),
		.res   (div_res)
	);

	always_comb begin
		case (ctrl.op)
			OP_MUL: begin
				done = mul_done;
				wb_val = mul_res;
				wb_clip = mul_clip;
			end
			OP_DIV6: begin
				done = div_done;
				wb_val = div_res;
				wb_clip = 1'b0;
			end
			default: begin
				done = 1'b1;
				wb_val = alu_res_q;
				wb_clip = alu_clip_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take)
			cmd_q <= cmd;
		if (ctrl.rd) begin
			a_q <= ctrl.sa[5] ? spec_a : mem[ctrl.sa[4:0]];
			b_q <= ctrl.sb[5] ? spec_b : mem[ctrl.sb[4:0]];
		end
		if (ctrl.start) begin
			alu_res_q <= alu_res;
			alu_clip_q <= alu_clip;
		end
		if (ctrl.wb && !ctrl.dst[5])
			mem[ctrl.dst[4:0]] <= wb_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= SIG_RST;
			rho_q <= RHO_RST;
			beta_q <= BETA_RST;
			dt_q <= DT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIGMA: sig_q <= cfg_data[30:0];
				CFG_RHO: rho_q <= cfg_data[30:0];
				CFG_BETA: beta_q <= cfg_data[30:0];
				CFG_DT: dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= POS_RST;
			py_q <= POS_RST;
			pz_q <= POS_RST;
			tx_q <= TAN_RST;
			ty_q <= '0;
			tz_q <= '0;
			clip_q <= 1'b0;
		end else begin
			if (take)
				clip_q <= 1'b0;
			else if (ctrl.wb)
				clip_q <= clip_q | wb_clip;
			if (ctrl.wb && ctrl.dst[5]) begin
				case (ctrl.dst)
					R_PX: px_q <= wb_val[WORD_BITS-1:0];
					R_PY: py_q <= wb_val[WORD_BITS-1:0];
					R_PZ: pz_q <= wb_val[WORD_BITS-1:0];
					R_TX: tx_q <= wb_val[WORD_BITS-1:0];
					R_TY: ty_q <= wb_val[WORD_BITS-1:0];
					R_TZ: tz_q <= wb_val[WORD_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		o_x = out32(px_q);
		o_y = out32(py_q);
		o_z = out32(pz_q);
		o_tx = out32(tx_q);
		o_ty = out32(ty_q);
		o_tz = out32(tz_q);
		rsp.out_x = o_x[31:0];
		rsp.out_y = o_y[31:0];
		rsp.out_z = o_z[31:0];
		rsp.out_tx = o_tx[31:0];
		rsp.out_ty = o_ty[31:0];
		rsp.out_tz = o_tz[31:0];
		rsp.saturated = clip_q | o_x[32] | o_y[32] | o_z[32] | o_tx[32] | o_ty[32]
			| o_tz[32];
	end

endmodule

@@ rtl/core/lrk_useq.sv @@
// Microcode sequencer: program ROM, micro program counter and step control.
// Uses lrk_pkg.
module lrk_useq import lrk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  logic      load,
	input  logic      unit_done,
	input  logic      slot_free,
	output seq_ctrl_t ctrl,
	output logic      busy
);

	localparam urom_t UROM = build_rom();

	sq_state_t        state_q, state_d;
	logic [UPC_W-1:0] upc_q;
	uword_t           uw_q;
	uword_t           cur;
	logic             load_q;

	assign cur = UROM[upc_q];

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (go) state_d = SQ_FETCH;
			SQ_FETCH: begin
				if (cur.op == OP_END)
					state_d = SQ_DONE;
				else if (cur.op != OP_JLD)
					state_d = SQ_READ;
			end
			SQ_READ: state_d = SQ_START;
			SQ_START: state_d = SQ_WAIT;
			SQ_WAIT: if (unit_done) state_d = SQ_WB;
			SQ_WB: state_d = SQ_FETCH;
			SQ_DONE: if (slot_free) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			upc_q <= '0;
			load_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_IDLE && go) begin
				upc_q <= '0;
				load_q <= load;
			end else if (state_q == SQ_FETCH && cur.op != OP_END) begin
				if (cur.op == OP_JLD && load_q)
					upc_q <= cur.tgt;
				else
					upc_q <= upc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_FETCH)
			uw_q <= cur;
	end

	always_comb begin
		ctrl.rd = state_q == SQ_READ;
		ctrl.start = state_q == SQ_START;
		ctrl.wb = state_q == SQ_WB;
		ctrl.fin = state_q == SQ_DONE && slot_free;
		ctrl.op = uw_q.op;
		ctrl.sh = uw_q.sh;
		ctrl.dst = uw_q.dst;
		ctrl.sa = uw_q.sa;
		ctrl.sb = uw_q.sb;
		busy = state_q != SQ_IDLE;
	end

endmodule

@@ rtl/core/lorenz_rk4_tangent_step_core.sv @@
// Lorenz RK4 step core with one tangent vector, signed fixed point.
// Top level; uses lrk_pkg, lrk_useq, lrk_dpath and the assertion header.
//
// Usage:
//   cmd channel: cmd_valid/cmd_stall carry one cmd_t word. action 0 runs one
//   RK4 step of the tangent (linearized at the old position) and then of the
//   position; action 1 loads position and tangent from the word.
//   rsp channel: rsp_valid/rsp_stall carry one rsp_t word per command with
//   the new state and the saturation flag.
//   cfg port: cfg_we writes cfg_data to sigma, rho, beta or dt by cfg_index;
//   write only while no command is in flight.
// Sequencing:
//   Each computing micro-op passes fetch, operand read, start, wait and write-back.
//   An add or clip leaves wait at once; a multiply or a divide by six stays in
//   wait while its unit works through four 32x32 partial products. One command
//   at a time, cmd_stall high until write-out, so no new command is taken
//   before the word of the last one is written out.
// Reset: config and state return to their defaults; no result is pending.
// Stall: the result waits in the output register; the next command may run
//   and holds before write-out until the register is free.
module lorenz_rk4_tangent_step_core import lrk_pkg::*; #(
	parameter int FRAC_BITS = 24,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "lorenz_rk4_tangent_step_core_assert.svh"

	seq_ctrl_t ctrl;
	logic      busy;
	logic      take;
	logic      unit_done;
	logic      slot_free;
	rsp_t      dp_rsp;
	rsp_t      rsp_q;
	logic      rsp_valid_q;

	assign cmd_stall = busy;
	assign take = cmd_valid && !busy;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	lrk_useq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (take),
		.load     (cmd.action),
		.unit_done(unit_done),
		.slot_free(slot_free),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	lrk_dpath #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.cmd      (cmd),
		.ctrl     (ctrl),
		.done     (unit_done),
		.rsp      (dp_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (ctrl.fin)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin)
			rsp_q <= dp_rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`LRK_ASSERT_NEXT(a_busy_after_take, take, cmd_stall)
	`LRK_ASSERT_IMPL(a_fin_slot_free, ctrl.fin, !(rsp_valid_q && rsp_stall))
	`LRK_ASSERT_NEXT(a_fin_gives_word, ctrl.fin, rsp_valid_q)

endmodule
